// ===== sv/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg: shared types and constants for the text console character writer
// Character codes, register indexes, controller states.
// ----------------------------------------------------------------------------
`default_nettype none
package tccw_pkg;
  localparam int MAX_CELLS_DEF = 16384;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [1:0] REG_COLUMNS    = 2'd0;
  localparam logic [1:0] REG_CELL_COUNT = 2'd1;
  localparam logic [1:0] REG_FORCE_ATTR = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_READ, ST_APPLY, ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== sv/tccw_div.sv =====
// ----------------------------------------------------------------------------
// tccw_div: serial floor divider
// Signed 18-bit dividend by unsigned 8-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tccw_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [17:0] dividend,
  input  wire logic        [7:0]  divisor,
  output logic                    done,
  output logic signed [17:0]      quotient
);
  logic [17:0] mag;
  logic [17:0] q;
  logic [8:0]  rem;
  logic [4:0]  cnt;
  logic        neg;
  logic        busy;
  logic [9:0]  trial;
  logic [17:0] qf;

  assign trial = {1'b0, rem[7:0], mag[17]} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd18;
        neg  <= dividend[17];
        mag  <= dividend[17] ? 18'(-dividend) : 18'(dividend);
        rem  <= '0;
        q    <= '0;
      end else if (busy) begin
        if (!trial[9]) begin
          rem <= trial[8:0];
          q   <= {q[16:0], 1'b1};
        end else begin
          rem <= {rem[7:0], mag[17]};
          q   <= {q[16:0], 1'b0};
        end
        mag <= {mag[16:0], 1'b0};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // q/rem final after last step; floor for negatives
  always_comb begin
    qf = q;
    if (neg) begin
      qf = 18'(-q);
      if (rem != 9'd0) qf = qf - 18'd1;
    end
  end
  assign quotient = qf;
endmodule
`default_nettype wire

// ===== sv/tccw_mem.sv =====
// ----------------------------------------------------------------------------
// tccw_mem: screen cell memory
// Single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module tccw_mem #(
  parameter int MAX_CELLS = tccw_pkg::MAX_CELLS_DEF,
  localparam int AW = $clog2(MAX_CELLS)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [15:0]   wdata,
  output logic      [15:0]   rdata
);
  logic [15:0] ram [MAX_CELLS];
  always_ff @(posedge clk) begin
    if (we) ram[addr] <= wdata;
    rdata <= ram[addr];
  end
endmodule
`default_nettype wire

// ===== sv/text_console_char_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_char_writer: text console character writer
// Writes character bytes into a cell memory and tracks cursor and origin.
// ----------------------------------------------------------------------------
// channel | dir | tdata bits (low up)
// s_axis  | in  | char_byte[7:0]
// m_axis  | out | accepted, cell_written, cell_address[13:0], cell_value[15:0],
//         |     | cursor_address[14:0], screen_origin[13:0], line_index[15:0]
// cfg     | in  | cfg_index selects register, cfg_data value
// One item at a time: the result is valid once a serial 18-step floor divider
// has found the line number and the memory has been read, modified and written
// back, and the next request is taken only once that result has been taken.
// After reset the memory is cleared one cell a cycle, all MAX_CELLS cells, while
// s_tready is low. A result held in m_axis stalls the next item.
`default_nettype none
module text_console_char_writer #(
  parameter int MAX_CELLS = tccw_pkg::MAX_CELLS_DEF,
  localparam int AW = $clog2(MAX_CELLS)
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // char_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // accepted, cell_written, cell_address,
                                      // cell_value, cursor_address,
                                      // screen_origin, line_index, pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);
  localparam int PW = AW + 2;  // position width, signed
  typedef logic signed [PW-1:0] pos_t;

  tccw_pkg::state_t state, state_next;
  logic [7:0]  columns;
  logic [14:0] cell_count;
  logic        force_attr;
  logic [AW:0] clr;
  pos_t origin, next_cell, last_cell;
  logic [15:0] line_number;
  logic [7:0]  cur_attr, ch;
  logic [7:0]  key;
  logic [7:0]  w;
  pos_t cap;
  logic        acc, wr;
  logic [AW-1:0] waddr;
  logic [15:0] wval;

  logic        mem_we;
  logic [AW-1:0] mem_addr;
  logic [15:0] mem_wdata, mem_rdata;

  logic        div_start, div_done;
  logic signed [17:0] div_num, div_q;
  pos_t base;

  assign w   = (columns == 8'd0) ? 8'd1 : columns;
  assign cap = (32'(cell_count) > 32'(MAX_CELLS)) ? pos_t'(MAX_CELLS)
                                                  : pos_t'(cell_count);
  assign cfg_ready = 1'b1;
  assign s_tready  = (state == tccw_pkg::ST_IDLE) && !m_tvalid;

  tccw_mem #(.MAX_CELLS(MAX_CELLS)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );
  tccw_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num),
    .divisor(w), .done(div_done), .quotient(div_q)
  );

  // incoming byte while idle, held byte afterwards
  assign key = (state == tccw_pkg::ST_IDLE) ? s_tdata : ch;

  // position whose line the divider computes
  always_comb begin
    base = last_cell;
    case (key)
      tccw_pkg::CH_LF: base = ((last_cell + pos_t'(w)) >= cap) ? last_cell
                                                                : last_cell + pos_t'(w);
      tccw_pkg::CH_BS: base = (next_cell > 0) ? next_cell - pos_t'(1) : pos_t'(0);
      default: base = last_cell;
    endcase
  end
  assign div_num   = 18'(base - origin);
  assign div_start = (state == tccw_pkg::ST_IDLE) && s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      tccw_pkg::ST_CLEAR: if (clr == (AW+1)'(MAX_CELLS - 1)) state_next = tccw_pkg::ST_IDLE;
      tccw_pkg::ST_IDLE:  if (div_start) state_next = tccw_pkg::ST_DIV;
      tccw_pkg::ST_DIV:   if (div_done) state_next = tccw_pkg::ST_READ;
      tccw_pkg::ST_READ:  state_next = tccw_pkg::ST_APPLY;
      tccw_pkg::ST_APPLY: state_next = tccw_pkg::ST_OUT;
      tccw_pkg::ST_OUT:   state_next = tccw_pkg::ST_IDLE;
      default:            state_next = tccw_pkg::ST_IDLE;
    endcase
  end

  logic printable, in_range;
  assign printable = (ch >= 8'h20) && (ch <= 8'h7E);
  assign in_range  = next_cell < cap;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = next_cell[AW-1:0];
    mem_wdata = '0;
    unique case (state)
      tccw_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr[AW-1:0];
      end
      tccw_pkg::ST_READ: begin
        mem_addr = (ch == tccw_pkg::CH_BS) ? base[AW-1:0] : next_cell[AW-1:0];
      end
      tccw_pkg::ST_APPLY: begin
        mem_we = printable && in_range;
        mem_wdata = {force_attr ? cur_attr : mem_rdata[15:8], ch};
      end
      default: ;
    endcase
  end

  pos_t fo, cr;
  logic signed [33:0] prod;
  assign prod = 34'(div_q) * 34'(w);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tccw_pkg::ST_CLEAR;
      clr <= '0;
      columns <= 8'd80;
      cell_count <= 15'd16384;
      force_attr <= 1'b0;
      origin <= '0; next_cell <= '0; last_cell <= '0;
      line_number <= '0;
      cur_attr <= 8'h07;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tccw_pkg::ST_CLEAR) clr <= clr + (AW+1)'(1);
      if (cfg_valid) begin
        case (cfg_index)
          tccw_pkg::REG_COLUMNS:    columns <= cfg_data[7:0];
          tccw_pkg::REG_CELL_COUNT: cell_count <= cfg_data;
          tccw_pkg::REG_FORCE_ATTR: force_attr <= cfg_data[0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (div_start) ch <= s_tdata;
      if (state == tccw_pkg::ST_DIV && div_done) begin
        fo <= origin + pos_t'(prod) + pos_t'(w);
        cr <= origin + pos_t'(prod);
      end
      if (state == tccw_pkg::ST_APPLY) begin
        acc <= 1'b1; wr <= 1'b0; waddr <= '0; wval <= '0;
        if (printable) begin
          if (in_range) begin
            wr <= 1'b1; waddr <= next_cell[AW-1:0]; wval <= mem_wdata;
          end
          last_cell <= (cap == 0) ? pos_t'(0) :
                       (next_cell < cap - pos_t'(1)) ? next_cell : cap - pos_t'(1);
          next_cell <= (next_cell + pos_t'(1) < cap) ? next_cell + pos_t'(1) : cap;
        end else begin
          case (ch)
            tccw_pkg::CH_NUL: ;
            tccw_pkg::CH_LF: begin
              last_cell <= base; next_cell <= base; line_number <= div_q[15:0];
            end
            tccw_pkg::CH_CR: begin
              // a line start below zero is less than one line under zero, so
              // the line of zero is the same line
              if (cr < 0) begin
                last_cell <= '0; next_cell <= '0; line_number <= div_q[15:0];
              end else begin
                last_cell <= cr; next_cell <= cr; line_number <= div_q[15:0];
              end
            end
            tccw_pkg::CH_BS: begin
              last_cell <= base; next_cell <= base; line_number <= div_q[15:0];
              cur_attr <= mem_rdata[15:8];
            end
            tccw_pkg::CH_FF: begin
              if (fo >= 0 && fo < cap) begin
                origin <= fo; last_cell <= fo; next_cell <= fo; line_number <= '0;
              end
            end
            default: acc <= 1'b0;
          endcase
        end
      end
      if (state == tccw_pkg::ST_OUT) m_tvalid <= 1'b1;
    end
  end

  assign m_tdata = {3'b000, line_number, 14'(origin), 15'(next_cell),
                    wval, 14'(waddr), wr, acc};
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for the text console character writer
// Streams character bytes through the block under random bursts and output
// stalls, predicts every result with a behavioral screen model and compares
// each result field by field. Configuration is changed between phases.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  localparam int NCELLS = 16384;
  localparam int IDLE_LIMIT = 100000;

  logic clk, rst;
  logic s_tvalid, s_tready;
  logic [7:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [79:0] m_tdata;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [14:0] cfg_data;

  text_console_char_writer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [15:0] line_index;
    logic [13:0] screen_origin;
    logic [14:0] cursor_address;
    logic [15:0] cell_value;
    logic [13:0] cell_address;
    logic        cell_written;
    logic        accepted;
  } screen_result_t;

  // screen model
  logic [15:0] scr_mem [NCELLS];
  int org, cur, last, lnum;
  logic [7:0] attr;
  int cols, cells;
  bit force_attr;

  screen_result_t pending_results[$];
  logic [7:0] char_queue[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0, gap_left = 0;
  int stall_phase = 0;
  bit hold_tx = 0;
  bit tx_acc = 0;

  function automatic int fdiv(int a, int d);
    if (a >= 0) return a / d;
    return -((-a + d - 1) / d);
  endfunction

  function automatic screen_result_t predict_char(logic [7:0] ch);
    screen_result_t r;
    int w, cap, p, ln;
    logic [7:0] a;
    w = (cols == 0) ? 1 : cols;
    cap = (cells > NCELLS) ? NCELLS : cells;
    r = '0;
    r.accepted = 1;
    if (ch >= 8'h20 && ch <= 8'h7E) begin
      if (cur < cap) begin
        a = force_attr ? attr : scr_mem[cur][15:8];
        r.cell_value = {a, ch};
        r.cell_address = cur[13:0];
        r.cell_written = 1;
        scr_mem[cur] = {a, ch};
      end
      if (cap == 0) last = 0;
      else last = (cur < cap - 1) ? cur : cap - 1;
      cur = (cur + 1 < cap) ? cur + 1 : cap;
    end else if (ch == tccw_pkg::CH_NUL) begin
    end else if (ch == tccw_pkg::CH_LF) begin
      p = last + w;
      if (p >= cap) p = last;
      lnum = fdiv(p - org, w);
      last = p; cur = p;
    end else if (ch == tccw_pkg::CH_CR) begin
      ln = fdiv(last - org, w);
      p = org + ln * w;
      if (p < 0) p = 0;
      lnum = fdiv(p - org, w);
      last = p; cur = p;
    end else if (ch == tccw_pkg::CH_BS) begin
      cur = (cur - 1 > 0) ? cur - 1 : 0;
      last = cur;
      lnum = fdiv(last - org, w);
      attr = (last < NCELLS) ? scr_mem[last][15:8] : 8'h00;
    end else if (ch == tccw_pkg::CH_FF) begin
      ln = fdiv(last - org, w) + 1;
      p = org + ln * w;
      if (p >= 0 && p < cap) begin
        org = p; lnum = 0; last = p; cur = p;
      end
    end else begin
      r.accepted = 0;
    end
    r.cursor_address = cur[14:0];
    r.screen_origin = org[13:0];
    r.line_index = lnum[15:0];
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // sender: bursts with gaps
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
      s_tdata <= '0;
    end else if (!s_tvalid || tx_acc) begin
      tx_acc = 0;
      if (gap_left > 0) gap_left--;
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
      end
      if (!hold_tx && gap_left == 0 && burst_left > 0 && char_queue.size() > 0) begin
        s_tvalid <= 1;
        s_tdata <= char_queue[0];
        burst_left--;
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst) m_tready <= 0;
    else begin
      stall_phase <= (stall_phase + 1) % 97;
      if (stall_phase < 20) m_tready <= 1;
      else if (stall_phase < 40) m_tready <= (stall_phase % 3) != 0;
      else m_tready <= $urandom_range(0, 2) != 0;
    end
  end

  // predictor on accepted requests, checker on results
  always @(posedge clk) begin
    screen_result_t got, exp_r;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pending_results.push_back(predict_char(s_tdata));
        void'(char_queue.pop_front());
        tx_acc = 1;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[76:0];
        if (pending_results.size() == 0) begin
          $error("unexpected result %h", m_tdata);
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          if (got.accepted !== exp_r.accepted) begin
            $error("accepted exp %0d got %0d", exp_r.accepted, got.accepted); errors++;
          end
          if (got.cell_written !== exp_r.cell_written) begin
            $error("cell_written exp %0d got %0d", exp_r.cell_written, got.cell_written);
            errors++;
          end
          if (got.cell_address !== exp_r.cell_address) begin
            $error("cell_address exp %0d got %0d", exp_r.cell_address, got.cell_address);
            errors++;
          end
          if (got.cell_value !== exp_r.cell_value) begin
            $error("cell_value exp %h got %h", exp_r.cell_value, got.cell_value); errors++;
          end
          if (got.cursor_address !== exp_r.cursor_address) begin
            $error("cursor_address exp %0d got %0d", exp_r.cursor_address,
                   got.cursor_address);
            errors++;
          end
          if (got.screen_origin !== exp_r.screen_origin) begin
            $error("screen_origin exp %0d got %0d", exp_r.screen_origin, got.screen_origin);
            errors++;
          end
          if (got.line_index !== exp_r.line_index) begin
            $error("line_index exp %0d got %0d", $signed(exp_r.line_index),
                   $signed(got.line_index));
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == tccw_pkg::REG_COLUMNS) cols = val[7:0];
    else if (idx == tccw_pkg::REG_CELL_COUNT) cells = val;
    else if (idx == tccw_pkg::REG_FORCE_ATTR) force_attr = val[0];
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic wait_drained();
    while (char_queue.size() != 0 || s_tvalid || pending_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_char();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 8'($urandom_range(8'h20, 8'h7E));
    if (k < 70) return tccw_pkg::CH_LF;
    if (k < 76) return tccw_pkg::CH_CR;
    if (k < 84) return tccw_pkg::CH_BS;
    if (k < 88) return tccw_pkg::CH_FF;
    if (k < 91) return tccw_pkg::CH_NUL;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic run_phase(int cnt);
    repeat (cnt) char_queue.push_back(rand_char());
  endtask

  initial begin
    logic [7:0] directed[] = '{8'h20, 8'h7E, 8'h41, tccw_pkg::CH_BS, 8'h42,
                               tccw_pkg::CH_LF, 8'h43, tccw_pkg::CH_CR,
                               tccw_pkg::CH_FF, tccw_pkg::CH_NUL, 8'h09, 8'h1B,
                               8'h7F, 8'h80, 8'hFF, tccw_pkg::CH_BS,
                               tccw_pkg::CH_BS, tccw_pkg::CH_BS, 8'h5A,
                               tccw_pkg::CH_LF, tccw_pkg::CH_FF, 8'h55, 8'hAA};
    for (int i = 0; i < NCELLS; i++) scr_mem[i] = '0;
    org = 0; cur = 0; last = 0; lnum = 0; attr = 8'h07;
    cols = 80; cells = 16384; force_attr = 0;
    rst = 1; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst = 0;

    foreach (directed[i]) char_queue.push_back(directed[i]);
    wait_drained();
    run_phase(200);
    wait_drained();

    write_reg(tccw_pkg::REG_FORCE_ATTR, 15'd1);
    write_reg(tccw_pkg::REG_COLUMNS, 15'd1);
    write_reg(tccw_pkg::REG_CELL_COUNT, 15'd3);
    repeat (25) char_queue.push_back(directed[$urandom_range(0, directed.size() - 1)]);
    run_phase(150);
    wait_drained();

    write_reg(tccw_pkg::REG_COLUMNS, 15'd255);
    write_reg(tccw_pkg::REG_CELL_COUNT, 15'd600);
    run_phase(300);
    // hold the sender until everything is back
    hold_tx = 1;
    while (pending_results.size() != 0 || s_tvalid) @(posedge clk);
    hold_tx = 0;
    wait_drained();

    write_reg(tccw_pkg::REG_CELL_COUNT, 15'd0);
    write_reg(tccw_pkg::REG_COLUMNS, 15'd0);
    run_phase(100);
    wait_drained();

    write_reg(tccw_pkg::REG_CELL_COUNT, 15'h7FFF);
    write_reg(tccw_pkg::REG_COLUMNS, 15'd7);
    write_reg(tccw_pkg::REG_FORCE_ATTR, 15'd0);
    run_phase(400);
    wait_drained();

    write_reg(tccw_pkg::REG_CELL_COUNT, 15'd40);
    write_reg(tccw_pkg::REG_COLUMNS, 15'd5);
    write_reg(tccw_pkg::REG_FORCE_ATTR, 15'd1);
    run_phase(400);
    wait_drained();

    write_reg(tccw_pkg::REG_CELL_COUNT, 15'd16384);
    write_reg(tccw_pkg::REG_COLUMNS, 15'd80);
    write_reg(tccw_pkg::REG_FORCE_ATTR, 15'd0);
    run_phase(450);
    wait_drained();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
